[hdl/sdd_pkg.sv]
// Shared beat type for the duplicate detector cell chain.
`default_nettype none

package sdd_pkg;

  // One beat as it moves down the cell chain, with the results gathered so far.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               first;
    logic               last;
    logic               epoch;
    logic               hit;
    logic               stored;
    logic               report;
  } beat_t;

endpackage

`default_nettype wire

[hdl/sdd_cell.sv]
// One cell of the chain: holds a single stored value and checks each passing beat against it.
`default_nettype none

module sdd_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  sdd_pkg::beat_t     beat_in,
  output sdd_pkg::beat_t     beat_out
);

  logic               held_valid_r;
  logic               epoch_r;
  logic signed [31:0] value_r;
  logic               reported_r;
  logic               beat_valid_r;
  sdd_pkg::beat_t     beat_data_r;

  logic               live;
  logic               match;
  logic               claim;
  sdd_pkg::beat_t     beat_nxt;

  // The entry counts only if it was written in the beat's own list.
  assign live  = held_valid_r && (epoch_r == beat_in.epoch);
  assign match = live && (value_r == beat_in.value);
  assign claim = !live && !beat_in.hit && !beat_in.stored;

  // Fold this cell's outcome into the passing beat.
  always_comb begin
    beat_nxt = beat_in;
    if (match) begin
      beat_nxt.hit    = 1'b1;
      beat_nxt.report = !reported_r;
    end
    if (claim) begin
      beat_nxt.stored = 1'b1;
    end
  end

  // Entry control state; a beat from a newer list retires a stale entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      epoch_r      <= 1'b0;
    end else if (advance && beat_in.valid) begin
      held_valid_r <= live || claim;
      epoch_r      <= beat_in.epoch;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (advance && beat_in.valid) begin
      if (claim) begin
        value_r    <= beat_in.value;
        reported_r <= 1'b0;
      end else if (match) begin
        reported_r <= 1'b1;
      end
    end
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (advance) begin
      beat_valid_r <= beat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_data_r <= beat_nxt;
    end
  end

  always_comb begin
    beat_out       = beat_data_r;
    beat_out.valid = beat_valid_r;
  end

endmodule

`default_nettype wire

[hdl/stream_duplicate_detector_core.sv]
// Top level of the stream duplicate detector: input tagging, cell chain and result register.
`default_nettype none

// Finds repeated values in a stream of signed 32-bit list elements. Each input beat walks a
// chain of STORE_DEPTH cells, one cell per cycle unless the result is stalled; each cell keeps
// one distinct value of the current list and a reported mark. A new value settles in the first
// empty cell, and a value that meets its own stored copy for the first time comes out with
// report set. A beat with first set opens a new list: cells written under the previous list are
// dropped as it passes. Every input beat gives exactly one result beat, in order. A new beat
// can enter every cycle unless the result is stalled, so the sustained rate is one item per
// cycle; each beat passes through the STORE_DEPTH cell registers and then the result register.
// When the result is stalled the whole chain holds and the input is stalled with it.
module stream_duplicate_detector_core #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_first,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_echo_value,
  output logic                    out_report,
  output logic                    out_any_found,
  output logic                    out_overflow,
  output logic                    out_end_of_list
);

  sdd_pkg::beat_t     chain [STORE_DEPTH+1];
  sdd_pkg::beat_t     head_beat;
  logic               advance;
  logic               epoch_r;
  logic               found_r;
  logic               out_valid_r;
  logic signed [31:0] out_echo_value_r;
  logic               out_report_r;
  logic               out_any_found_r;
  logic               out_overflow_r;
  logic               out_end_of_list_r;
  logic               load;
  logic               any_nxt;
  sdd_pkg::beat_t     tail;

  // The chain moves whenever the result register is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // List epoch flips on each first beat so cells can tell stale entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= 1'b0;
    end else if (in_valid && advance && in_first) begin
      epoch_r <= !epoch_r;
    end
  end

  // Head of the chain: the incoming beat with empty results.
  always_comb begin
    head_beat.valid  = in_valid;
    head_beat.value  = in_value;
    head_beat.first  = in_first;
    head_beat.last   = in_last;
    head_beat.epoch  = epoch_r ^ in_first;
    head_beat.hit    = 1'b0;
    head_beat.stored = 1'b0;
    head_beat.report = 1'b0;
  end

  assign chain[0] = head_beat;

  // Row of store cells.
  for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
    sdd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .beat_in  (chain[gi]),
      .beat_out (chain[gi+1])
    );
  end

  assign tail    = chain[STORE_DEPTH];
  assign load    = advance && tail.valid;
  assign any_nxt = (found_r && !tail.first) || tail.report;

  // Running found flag, kept in result order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= tail.valid;
      end
      if (load) begin
        found_r <= any_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_echo_value_r  <= tail.value;
      out_report_r      <= tail.report;
      out_any_found_r   <= any_nxt;
      out_overflow_r    <= !tail.hit && !tail.stored;
      out_end_of_list_r <= tail.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_value  = out_echo_value_r;
  assign out_report      = out_report_r;
  assign out_any_found   = out_any_found_r;
  assign out_overflow    = out_overflow_r;
  assign out_end_of_list = out_end_of_list_r;

  // A reported beat was found in the store, so it cannot also have overflowed.
  a_report_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_report_r && out_overflow_r))
    else $error("report and overflow set on the same result beat");

  // A result that reports a duplicate must show the running flag set.
  a_report_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_report_r |-> out_any_found_r)
    else $error("reported duplicate without any_found");

  // The found flag clears only when a first beat reaches the result register.
  a_found_clears_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(found_r) |-> $past(load && tail.first))
    else $error("found flag cleared without a new list");

endmodule

`default_nettype wire
